[sv/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg: shared types for the selective-repeat receiver
// Controller states and the command and status groups that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package srr_pkg;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ACK,
    S_DELIV
  } srr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;      // take the frame on the input channel this cycle
    logic emit_ack;    // load the acknowledgment into the output register
    logic emit_deliv;  // load the delivery at the window base, advance base
  } srr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic head_filled;  // slot at the window base holds a frame
    logic next_filled;  // slot after the window base holds a frame
  } srr_status_t;

endpackage

[sv/srr_ram.sv]
// ----------------------------------------------------------------------------
// srr_ram: generic simple dual-port RAM
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module srr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/srr_ctrl.sv]
// ----------------------------------------------------------------------------
// srr_ctrl: controller for the selective-repeat receiver
// Takes one frame, emits its acknowledgment, then walks the in-order
// deliveries until the slot after the base is empty.
// ----------------------------------------------------------------------------
module srr_ctrl
  import srr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  srr_status_t status,
  output srr_cmd_t    cmd
);

  srr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_ACK;
      end
      S_ACK: begin
        if (status.out_free) state_nxt = status.head_filled ? S_DELIV : S_IDLE;
      end
      S_DELIV: begin
        if (status.out_free) state_nxt = status.next_filled ? S_DELIV : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready      = 1'b0;
    cmd.accept     = 1'b0;
    cmd.emit_ack   = 1'b0;
    cmd.emit_deliv = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      S_ACK: begin
        cmd.emit_ack = status.out_free;
      end
      S_DELIV: begin
        cmd.emit_deliv = status.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

[sv/srr_dp.sv]
// ----------------------------------------------------------------------------
// srr_dp: datapath for the selective-repeat receiver
// Window base, slot valid bits, slot byte RAM and the output register.
// ----------------------------------------------------------------------------
module srr_dp
  import srr_pkg::*;
#(
  parameter int WINDOW = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  frame_seq,
  input  logic [7:0]  frame_byte,
  input  srr_cmd_t    cmd,
  output srr_status_t status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_kind,
  output logic [2:0]  out_seq,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  localparam int SEQ_SPACE = 2 * WINDOW;
  localparam int SEQ_W = $clog2(SEQ_SPACE);
  // Wide enough for a raw 3-bit number, any slot number and the space itself.
  localparam int RED_W = ((SEQ_W > 3) ? SEQ_W : 3) + 1;

  logic [SEQ_W-1:0]     base_r, base_inc, seq_red, seq_r, rd_addr;
  logic [SEQ_SPACE-1:0] filled_r;
  logic [RED_W-1:0]     seq_tmp, seq_ext, base_ext;
  logic [SEQ_W:0]       diff, offset;
  logic                 in_win, store;
  logic [7:0]           slot_rdata;

  logic       out_valid_r, out_kind_r, out_last_r;
  logic [2:0] out_seq_r;
  logic [7:0] out_byte_r;

  // Fold the arriving number into the sequence space: at most four
  // subtractions cover the smallest space.
  always_comb begin
    seq_tmp = RED_W'(frame_seq);
    for (int k = 0; k < 4; k++) begin
      if (seq_tmp >= RED_W'(SEQ_SPACE)) seq_tmp = seq_tmp - RED_W'(SEQ_SPACE);
    end
    seq_red = seq_tmp[SEQ_W-1:0];
  end

  // Distance from the base, taken around the sequence space.
  assign diff   = {1'b0, seq_red} - {1'b0, base_r};
  assign offset = diff[SEQ_W] ? diff + (SEQ_W+1)'(SEQ_SPACE) : diff;
  assign in_win = offset < (SEQ_W+1)'(WINDOW);
  assign store  = cmd.accept && in_win && !filled_r[seq_red];

  assign base_inc = (base_r == SEQ_W'(SEQ_SPACE - 1)) ? '0 : base_r + 1'b1;

  // The RAM reads the base continuously; when the base advances, the read
  // follows it so the byte at the new base is ready in the next cycle.
  assign rd_addr = cmd.emit_deliv ? base_inc : base_r;

  srr_ram #(
    .WIDTH(8),
    .DEPTH(SEQ_SPACE)
  ) u_slot_ram (
    .clk  (clk),
    .we   (store),
    .waddr(seq_red),
    .wdata(frame_byte),
    .raddr(rd_addr),
    .rdata(slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      filled_r <= '0;
    end else begin
      if (store) filled_r[seq_red] <= 1'b1;
      if (cmd.emit_deliv) begin
        filled_r[base_r] <= 1'b0;
        base_r           <= base_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) seq_r <= seq_red;
  end

  assign seq_ext  = RED_W'(seq_r);
  assign base_ext = RED_W'(base_r);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ack || cmd.emit_deliv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_ack) begin
      out_kind_r <= 1'b0;
      out_seq_r  <= seq_ext[2:0];
      out_byte_r <= '0;
      out_last_r <= !filled_r[base_r];
    end else if (cmd.emit_deliv) begin
      out_kind_r <= 1'b1;
      out_seq_r  <= base_ext[2:0];
      out_byte_r <= slot_rdata;
      out_last_r <= !filled_r[base_inc];
    end
  end

  assign status.out_free    = !out_valid_r || out_ready;
  assign status.head_filled = filled_r[base_r];
  assign status.next_filled = filled_r[base_inc];

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_seq   = out_seq_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

[sv/selective_repeat_receiver.sv]
// ----------------------------------------------------------------------------
// selective_repeat_receiver: receiver side of selective-repeat ARQ
// Stores frames that fall in the receive window, acknowledges every frame and
// delivers the bytes upward in sequence order.
// ----------------------------------------------------------------------------
// Each request on the input channel is one arriving frame. The sequence
// number is first folded into the space of 2*WINDOW numbers. A frame whose
// distance from the window base is below WINDOW is stored in its slot unless
// that slot already holds a frame, in which case the new byte is dropped; any
// other frame is a repeat from the previous window and is not stored. Every
// frame gives one acknowledgment (tuser low), followed by one delivery
// (tuser high) for each consecutive filled slot starting at the window base,
// each of which frees its slot and moves the base on by one. The last result
// caused by a frame carries tlast. The controller accepts a frame in S_IDLE,
// storing it if due, sends its acknowledgment in S_ACK and then one delivered
// byte per visit to S_DELIV, the last two states waiting while the output
// register cannot take a result, since all results pass through a single
// output register and the slot bytes come from a RAM with one registered
// read port. The input is not ready while a frame's results are still being
// sent, but a finished result may wait in the output register while the next
// frame is accepted. Slot valid bits are flip-flops cleared by reset, so no
// clearing pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module selective_repeat_receiver
  import srr_pkg::*;
#(
  parameter int WINDOW = 4  // receive window size, 1 to 32
) (
  input  logic        clk,
  input  logic        rst_n,

  // Arriving frames.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] frame_seq, [10:3] frame_byte, rest zero

  // Acknowledgments and deliveries.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [2:0] seq_field, [10:3] byte_out, rest zero
  output logic        out_tuser,  // [0] kind: 0 acknowledgment, 1 delivery
  output logic        out_tlast   // final result caused by this frame
);

  srr_cmd_t    cmd;
  srr_status_t status;
  logic [2:0]  out_seq;
  logic [7:0]  out_byte;

  srr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  srr_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_seq (in_tdata[2:0]),
    .frame_byte(in_tdata[10:3]),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_kind  (out_tuser),
    .out_seq   (out_seq),
    .out_byte  (out_byte),
    .out_last  (out_tlast)
  );

  assign out_tdata = {5'b0, out_byte, out_seq};

endmodule
